// ----- design/ctfp_pkg.sv -----
// Shared types, constants and helper functions of the color table fill pattern generator.
`default_nettype none

package ctfp_pkg;

  // Default table size.
  localparam int TableEntries = 256;
  // Rows in one fill pattern.
  localparam int PatternRows  = 16;

  // Field widths.
  localparam int IndexW = 8;
  localparam int ByteW  = 8;
  localparam int RowW   = 16;
  localparam int RowNumW = 4;
  localparam int IndexCount = 2 ** IndexW;

  // Stream widths.
  localparam int InDataW  = 32;
  localparam int InUserW  = 2;
  localparam int OutDataW = 48;
  localparam int OutUserW = 1;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Result kind carried on the output tuser.
  typedef enum logic [0:0] {
    KIND_READ    = 1'b0,
    KIND_PATTERN = 1'b1
  } kind_e;

  // One table entry, red in the lowest byte.
  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } color_t;

  // Access request from the controller to the table memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  // Control from the controller to the row generator.
  typedef struct packed {
    logic restart;
    logic step;
  } gen_ctrl_t;

  // Base masks picked by the red nibbles.
  localparam logic [RowW-1:0] MASK_TABLE [16] = '{
    16'h0000, 16'h8000, 16'h8080, 16'h8410, 16'h8888, 16'h9124, 16'h9494, 16'hA552,
    16'hAAAA, 16'hEB6E, 16'hDDDD, 16'hF7F7, 16'hFFFF, 16'hE3E3, 16'hFF00, 16'h00FF
  };

  // Index reduced into the table, by repeated subtraction; used for constant tables only.
  function automatic int wrap_index(input int idx, input int entries);
    int v;
    v = idx;
    for (int k = 0; k < IndexCount; k++) begin
      if (v >= entries) begin
        v = v - entries;
      end
    end
    return v;
  endfunction

  // One-bit rotations of a pattern word.
  function automatic logic [RowW-1:0] rot_right(input logic [RowW-1:0] w);
    return {w[0], w[RowW-1:1]};
  endfunction

  function automatic logic [RowW-1:0] rot_left(input logic [RowW-1:0] w);
    return {w[RowW-2:0], w[RowW-1]};
  endfunction

endpackage

`default_nettype wire

// ----- design/ctfp_color_mem.sv -----
// Color table memory with a clearing pass that loads the reset colors.
`default_nettype none

module ctfp_color_mem #(
  parameter int TABLE_ENTRIES = ctfp_pkg::TableEntries
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire ctfp_pkg::mem_ctrl_t                ctrl_i,
  input  wire logic [$clog2(TABLE_ENTRIES)-1:0]   addr_i,
  input  wire ctfp_pkg::color_t                   wr_data_i,
  output ctfp_pkg::color_t                        rd_data_o,
  output logic                                    busy_o
);

  localparam int AddrW = $clog2(TABLE_ENTRIES);
  // Only entries an 8-bit index can reach need their reset colors.
  localparam int ClearLen = (TABLE_ENTRIES < ctfp_pkg::IndexCount) ?
                            TABLE_ENTRIES : ctfp_pkg::IndexCount;
  localparam int ClearW = $clog2(ClearLen);

  ctfp_pkg::color_t mem_q [TABLE_ENTRIES];

  logic              clr_busy_q, clr_busy_d;
  logic [ClearW-1:0] clr_cnt_q, clr_cnt_d;
  logic [ctfp_pkg::ByteW-1:0] clr_byte;
  ctfp_pkg::color_t  clr_color;
  logic              wr_en;
  logic [AddrW-1:0]  wr_addr;
  ctfp_pkg::color_t  wr_data;

  // Reset color of the entry being cleared: red = blue = i, green = 255 - i.
  assign clr_byte  = ctfp_pkg::ByteW'(clr_cnt_q);
  assign clr_color = '{blue: clr_byte, green: ~clr_byte, red: clr_byte};

  // Sweep counter, one entry per cycle after reset.
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ClearW'(ClearLen - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // The sweep owns the write port while it runs.
  assign wr_en   = clr_busy_q | ctrl_i.wr_en;
  assign wr_addr = clr_busy_q ? AddrW'(clr_cnt_q) : addr_i;
  assign wr_data = clr_busy_q ? clr_color : wr_data_i;

  // One write port and one read port, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_o <= mem_q[addr_i];
    end
  end

  assign busy_o = clr_busy_q;

endmodule

`default_nettype wire

// ----- design/ctfp_row_gen.sv -----
// Fill pattern row generator: one row per step from the captured color entry.
`default_nettype none

module ctfp_row_gen (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ctfp_pkg::gen_ctrl_t           ctrl_i,
  input  wire ctfp_pkg::color_t              color_i,
  output logic [ctfp_pkg::RowW-1:0]          row_o
);

  logic [3:0] pos_q, pos_d;
  logic [ctfp_pkg::RowW-1:0] one_q, one_d, two_q, two_d;
  logic [3:0] a_nib, b_nib, a_rows, flags;
  logic [4:0] sum, total, pos_inc;
  logic       start_a, start_b, in_a;
  logic [ctfp_pkg::RowW-1:0] mask_a, mask_b, cur_one, cur_two;

  // Section sizes: an empty pattern gets one row of A, and the total clips at sixteen.
  assign a_nib  = color_i.green[3:0];
  assign b_nib  = color_i.green[7:4];
  assign a_rows = ((a_nib == 4'd0) && (b_nib == 4'd0)) ? 4'd1 : a_nib;
  assign sum    = {1'b0, a_rows} + {1'b0, b_nib};
  assign total  = (sum > 5'd16) ? 5'd16 : sum;

  assign mask_a = ctfp_pkg::MASK_TABLE[color_i.red[3:0]];
  assign mask_b = ctfp_pkg::MASK_TABLE[color_i.red[7:4]];

  // Position within the period picks the section and whether its words reload.
  assign start_b = (pos_q == a_rows);
  assign start_a = (pos_q == 4'd0);
  assign in_a    = (pos_q < a_rows);
  assign flags   = in_a ? color_i.blue[3:0] : color_i.blue[7:4];

  always_comb begin
    if (start_b) begin
      cur_one = mask_b;
      cur_two = mask_b;
    end else if (start_a) begin
      cur_one = mask_a;
      cur_two = mask_a;
    end else begin
      cur_one = one_q;
      cur_two = two_q;
    end
  end

  assign row_o = cur_one | cur_two;

  // Rotations after each row, right before left, as the flags ask.
  always_comb begin
    one_d = cur_one;
    two_d = cur_two;
    if (flags[0]) one_d = ctfp_pkg::rot_right(one_d);
    if (flags[1]) one_d = ctfp_pkg::rot_left(one_d);
    if (flags[2]) two_d = ctfp_pkg::rot_right(two_d);
    if (flags[3]) two_d = ctfp_pkg::rot_left(two_d);
  end

  // The period wraps back to row zero, which repeats the earlier rows.
  assign pos_inc = {1'b0, pos_q} + 5'd1;

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.restart) begin
      pos_d = '0;
    end else if (ctrl_i.step) begin
      pos_d = (pos_inc == total) ? 4'd0 : pos_inc[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      one_q <= one_d;
      two_q <= two_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/color_table_fill_pattern_generator.sv -----
// Top level: item control, table memory, row generator and the output register.
`default_nettype none

// A write item stores its entry at the accepting edge, gives no beat, and the next item can be
// taken in the following cycle. A read item reads the table at the accepting edge. The entry is
// captured in the lookup state, and its beat is loaded into the output register from the
// deliver state. The next item is taken once that beat has been loaded. A fill item reads the
// entry the same way and then loads sixteen pattern rows, one per cycle while the output side
// keeps up. The next item is taken once the last row has been loaded. After reset a clearing
// pass writes the reset colors into the first min(TABLE_ENTRIES, 256) entries, one per cycle,
// and no item is taken until it ends.
module color_table_fill_pattern_generator #(
  parameter int TABLE_ENTRIES = ctfp_pkg::TableEntries
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // index[7:0], red_value[15:8], green_value[23:16], blue_value[31:24]
  input  wire logic [ctfp_pkg::InDataW-1:0]      s_axis_tdata_i,
  // operation[1:0]
  input  wire logic [ctfp_pkg::InUserW-1:0]      s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // red_out[7:0], green_out[15:8], blue_out[23:16], pattern_row[39:24],
  // row_number[43:40], zero fill[47:44]
  output logic [ctfp_pkg::OutDataW-1:0]          m_axis_tdata_o,
  // result_kind[0]
  output logic [ctfp_pkg::OutUserW-1:0]          m_axis_tuser_o,
  // last_row
  output logic                                   m_axis_tlast_o
);

  localparam int AddrW = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_LOOKUP  = 4'b0010,
    ST_DELIVER = 4'b0100,
    ST_PATTERN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [ctfp_pkg::IndexW-1:0] in_index;
  ctfp_pkg::color_t             in_color;
  ctfp_pkg::op_e                in_op;
  logic                         in_beat;
  logic [AddrW-1:0]             wrap_lut [ctfp_pkg::IndexCount];
  logic [AddrW-1:0]             mem_addr;
  ctfp_pkg::mem_ctrl_t          mem_ctrl;
  ctfp_pkg::color_t             mem_rdata;
  logic                         mem_busy;
  ctfp_pkg::gen_ctrl_t          gen_ctrl;
  logic [ctfp_pkg::RowW-1:0]    gen_row;

  ctfp_pkg::op_e                op_q;
  ctfp_pkg::color_t             color_q;
  logic [ctfp_pkg::RowNumW-1:0] row_q, row_d;

  logic                         out_valid_q, out_valid_d;
  logic                         load_ok, load_read, load_row;
  logic                         last_pattern_row;
  ctfp_pkg::kind_e              out_kind_q;
  ctfp_pkg::color_t             out_color_q;
  logic [ctfp_pkg::RowW-1:0]    out_row_q;
  logic [ctfp_pkg::RowNumW-1:0] out_num_q;
  logic                         out_last_q;

  // Input beat unpacking.
  assign in_index = s_axis_tdata_i[7:0];
  assign in_color = '{blue:  s_axis_tdata_i[31:24],
                      green: s_axis_tdata_i[23:16],
                      red:   s_axis_tdata_i[15:8]};
  assign in_op    = ctfp_pkg::op_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == ST_IDLE) && !mem_busy;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  // Index wrap table: identity when the table covers every index.
  for (genvar g = 0; g < ctfp_pkg::IndexCount; g++) begin : g_wrap
    assign wrap_lut[g] = AddrW'(ctfp_pkg::wrap_index(g, TABLE_ENTRIES));
  end

  assign mem_addr       = wrap_lut[in_index];
  assign mem_ctrl.wr_en = in_beat && (in_op == ctfp_pkg::OP_WRITE);
  assign mem_ctrl.rd_en = in_beat && ((in_op == ctfp_pkg::OP_READ) ||
                                      (in_op == ctfp_pkg::OP_FILL));

  // Only one item is in flight, so a read never overlaps a write to the same entry.
  ctfp_color_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .addr_i    (mem_addr),
    .wr_data_i (in_color),
    .rd_data_o (mem_rdata),
    .busy_o    (mem_busy)
  );

  // The output register takes a new beat when empty or being drained.
  assign load_ok          = !out_valid_q || m_axis_tready_i;
  assign load_read        = (state_q == ST_DELIVER) && load_ok;
  assign load_row         = (state_q == ST_PATTERN) && load_ok;
  assign last_pattern_row = (row_q == ctfp_pkg::RowNumW'(ctfp_pkg::PatternRows - 1));

  assign gen_ctrl.restart = (state_q == ST_LOOKUP);
  assign gen_ctrl.step    = load_row;

  ctfp_row_gen u_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (gen_ctrl),
    .color_i (color_q),
    .row_o   (gen_row)
  );

  // Item sequencing.
  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    case (state_q)
      ST_IDLE: begin
        if (mem_ctrl.rd_en) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        row_d   = '0;
        state_d = (op_q == ctfp_pkg::OP_FILL) ? ST_PATTERN : ST_DELIVER;
      end
      ST_DELIVER: begin
        if (load_ok) begin
          state_d = ST_IDLE;
        end
      end
      ST_PATTERN: begin
        if (load_ok) begin
          row_d = row_q + 1'b1;
          if (last_pattern_row) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_read || load_row) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      row_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      row_q       <= row_d;
    end
  end

  // Item payload and output payload.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q <= in_op;
    end
    if (state_q == ST_LOOKUP) begin
      color_q <= mem_rdata;
    end
    if (load_read) begin
      out_kind_q  <= ctfp_pkg::KIND_READ;
      out_color_q <= color_q;
      out_row_q   <= '0;
      out_num_q   <= '0;
      out_last_q  <= 1'b1;
    end else if (load_row) begin
      out_kind_q  <= ctfp_pkg::KIND_PATTERN;
      out_color_q <= color_q;
      out_row_q   <= gen_row;
      out_num_q   <= row_q;
      out_last_q  <= last_pattern_row;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_num_q, out_row_q,
                            out_color_q.blue, out_color_q.green, out_color_q.red};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // No item enters while the clearing pass owns the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_busy |-> !in_beat)
    else $error("item accepted during the clearing pass");

  // A taken pattern row that is not the last is followed at once by the next row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && (out_kind_q == ctfp_pkg::KIND_PATTERN) &&
     !m_axis_tlast_o) |=> (m_axis_tvalid_o && (out_num_q == $past(out_num_q) + 1'b1)))
    else $error("pattern rows not delivered in sequence");

  // A pattern beat is flagged last exactly on its final row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_kind_q == ctfp_pkg::KIND_PATTERN)) |->
      (m_axis_tlast_o == (out_num_q == ctfp_pkg::RowNumW'(ctfp_pkg::PatternRows - 1))))
    else $error("last flag does not match the final pattern row");

endmodule

`default_nettype wire
